/* hw/rtl/lcar_pkg.sv */
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared types and constants for the load cell reader with tare.
// ----------------------------------------------------------------------------
package lcar_pkg;

    localparam int DATA_BITS  = 24;
    localparam int TIMER_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int BITCNT_W   = 5;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_W      = DATA_BITS + FRAC_BITS;
    localparam int DIVCNT_W   = $clog2(NUM_W);

    localparam logic [DATA_BITS-1:0] SIGN_FLIP = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic [GAIN_W-1:0]    GAIN_MIN  = 16'd256;
    localparam logic [GAIN_W-1:0]    GAIN_RST  = 16'd1386;
    localparam logic [TIMER_W-1:0]   HALF_RST  = 8'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 1'b1;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_TARE  = 2'd1;
    localparam logic [1:0] ACT_WEIGH = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_LAST_HIGH
    } t_phase;

    typedef struct packed {
        logic clear_shift;
        logic shift_in;
        logic finish;
        logic load_tare;
        logic start_div;
    } t_dp_cmd;

    typedef struct packed {
        logic               raw_gt_tare;
        logic               div_done;
        logic [TIMER_W-1:0] half_len;
    } t_dp_stat;

endpackage

/* hw/rtl/lcar_dp.sv */
// ----------------------------------------------------------------------------
// lcar_dp
// Datapath: config registers, input shift register, raw/tare/weight
// registers and a radix-2 restoring divider for the weight.
// ----------------------------------------------------------------------------
module lcar_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcar_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_dout,
    input  logic                              i_cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lcar_pkg::t_dp_stat                o_stat,
    output logic [lcar_pkg::DATA_BITS-1:0]    o_raw,
    output logic [lcar_pkg::DATA_BITS-1:0]    o_tare,
    output logic [lcar_pkg::DATA_BITS-1:0]    o_weight
);
    import lcar_pkg::*;

    logic [TIMER_W-1:0]   r_half;
    logic [GAIN_W-1:0]    r_gain;
    logic [DATA_BITS-1:0] r_shift;
    logic [DATA_BITS-1:0] r_raw;
    logic [DATA_BITS-1:0] r_tare;
    logic [DATA_BITS-1:0] r_weight;
    logic                 r_div_run;
    logic [DIVCNT_W-1:0]  r_div_cnt;
    logic [NUM_W-1:0]     r_dq;
    logic [GAIN_W-1:0]    r_rem;

    logic [DATA_BITS-1:0] raw_next;
    logic [DATA_BITS-1:0] diff;
    logic [GAIN_W-1:0]    gain_eff;
    logic [GAIN_W:0]      trial;
    logic [GAIN_W:0]      trial_sub;
    logic                 trial_ge;
    logic [NUM_W-1:0]     n_dq;
    logic                 div_last;

    assign raw_next  = r_shift ^ SIGN_FLIP;
    assign diff      = raw_next - r_tare;
    assign gain_eff  = (r_gain < GAIN_MIN) ? GAIN_MIN : r_gain;
    assign trial     = {r_rem, r_dq[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, gain_eff};
    assign trial_sub = trial - {1'b0, gain_eff};
    assign n_dq      = {r_dq[NUM_W-2:0], trial_ge};
    assign div_last  = r_div_run && (r_div_cnt == DIVCNT_W'(NUM_W - 1));

    assign o_stat.raw_gt_tare = raw_next > r_tare;
    assign o_stat.div_done    = div_last;
    assign o_stat.half_len    = (r_half == '0) ? TIMER_W'(1) : r_half;

    assign o_raw    = r_raw;
    assign o_tare   = r_tare;
    assign o_weight = r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RST;
            r_gain <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half <= i_cfg_data[TIMER_W-1:0];
                CFG_GAIN:        r_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (i_cmd.clear_shift) begin
            r_shift <= '0;
        end else if (i_cmd.shift_in) begin
            r_shift <= {r_shift[DATA_BITS-2:0], i_dout};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= '0;
            r_tare <= '0;
        end else if (i_cmd.finish) begin
            r_raw <= raw_next;
            if (i_cmd.load_tare) begin
                r_tare <= raw_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
            r_div_cnt <= '0;
            r_weight  <= '0;
        end else if (i_cmd.start_div) begin
            r_div_run <= 1'b1;
            r_div_cnt <= '0;
        end else if (r_div_run) begin
            r_div_cnt <= r_div_cnt + DIVCNT_W'(1);
            if (div_last) begin
                r_div_run <= 1'b0;
                r_weight  <= n_dq[DATA_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_dq  <= {diff, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end else if (r_div_run) begin
            r_dq  <= n_dq;
            r_rem <= trial_ge ? trial_sub[GAIN_W-1:0] : trial[GAIN_W-1:0];
        end
    end

endmodule

/* hw/rtl/lcar_ctrl.sv */
// ----------------------------------------------------------------------------
// lcar_ctrl
// Controller: serial clock sequencing, reading count and handshakes.
// ----------------------------------------------------------------------------
module lcar_ctrl #(
    parameter int READINGS_PER_WEIGH = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic                i_dout,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lcar_pkg::t_dp_stat  i_stat,
    output lcar_pkg::t_dp_cmd   o_cmd,
    output logic                o_sck,
    output logic                o_busy,
    output logic                o_done,
    output logic                o_updated
);
    import lcar_pkg::*;

    localparam int LEFT_W = $clog2(READINGS_PER_WEIGH + 1);

    t_phase              r_phase, n_phase;
    logic [BITCNT_W-1:0] r_bits, n_bits;
    logic [TIMER_W-1:0]  r_timer, n_timer;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_tare_mode, n_tare_mode;
    logic                r_sck, n_sck;
    logic                r_div_busy, n_div_busy;
    logic                r_out_valid, n_out_valid;
    logic                r_done, n_done;
    logic                r_updated, n_updated;

    logic                accept;
    logic                level_over;
    logic                start;
    logic                done;

    assign o_in_ready  = !r_div_busy && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign level_over  = r_timer <= TIMER_W'(1);
    assign o_out_valid = r_out_valid;
    assign o_sck       = r_sck;
    assign o_busy      = r_phase != PH_IDLE;
    assign o_done      = r_done;
    assign o_updated   = r_updated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bits      <= '0;
            r_timer     <= '0;
            r_left      <= '0;
            r_tare_mode <= 1'b0;
            r_sck       <= 1'b1;
            r_div_busy  <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_updated   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_bits      <= n_bits;
            r_timer     <= n_timer;
            r_left      <= n_left;
            r_tare_mode <= n_tare_mode;
            r_sck       <= n_sck;
            r_div_busy  <= n_div_busy;
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
            r_updated   <= n_updated;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_bits      = r_bits;
        n_timer     = r_timer;
        n_left      = r_left;
        n_tare_mode = r_tare_mode;
        n_sck       = r_sck;
        n_div_busy  = r_div_busy;
        n_done      = r_done;
        n_updated   = r_updated;
        o_cmd       = '0;
        start       = 1'b0;
        done        = 1'b0;

        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_action == ACT_TARE) begin
                        n_tare_mode = 1'b1;
                        n_left      = LEFT_W'(1);
                        start       = 1'b1;
                    end else if (i_action == ACT_WEIGH) begin
                        n_tare_mode = 1'b0;
                        n_left      = LEFT_W'(READINGS_PER_WEIGH);
                        start       = 1'b1;
                    end
                end
                PH_WAIT: begin
                    if (!i_dout) begin
                        n_sck   = 1'b1;
                        n_timer = i_stat.half_len;
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (level_over) begin
                        n_sck          = 1'b0;
                        o_cmd.shift_in = 1'b1;
                        n_bits         = r_bits + BITCNT_W'(1);
                        n_timer        = i_stat.half_len;
                        n_phase        = PH_LOW;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_LOW: begin
                    if (level_over) begin
                        n_sck   = 1'b1;
                        n_timer = i_stat.half_len;
                        n_phase = (r_bits < BITCNT_W'(DATA_BITS)) ? PH_HIGH : PH_LAST_HIGH;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_LAST_HIGH: begin
                    if (level_over) begin
                        n_sck        = 1'b0;
                        o_cmd.finish = 1'b1;
                        done         = 1'b1;
                        if (r_tare_mode) begin
                            o_cmd.load_tare = 1'b1;
                        end else if (i_stat.raw_gt_tare) begin
                            o_cmd.start_div = 1'b1;
                            n_div_busy      = 1'b1;
                        end
                        if (r_left > LEFT_W'(1)) begin
                            n_left = r_left - LEFT_W'(1);
                            start  = 1'b1;
                        end else begin
                            n_left  = '0;
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (start) begin
                n_sck             = 1'b0;
                o_cmd.clear_shift = 1'b1;
                n_bits            = '0;
                n_timer           = '0;
                n_phase           = PH_WAIT;
            end
            n_done    = done;
            n_updated = 1'b0;
        end

        // weight lands after the divider; the request is held back until then
        if (i_stat.div_done) begin
            n_div_busy = 1'b0;
            n_updated  = 1'b1;
        end

        n_out_valid = (accept && !o_cmd.start_div) || i_stat.div_done
                      || (r_out_valid && !i_out_ready);
    end

endmodule

/* hw/rtl/load_cell_adc_reader_with_tare.sv */
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_tare
// Serial 24-bit load cell converter reader with tare and weight scaling.
// ----------------------------------------------------------------------------
// Usage: every input request is one tick carrying the sampled data-out level
// and an action (none, tare, weigh; actions are ignored while busy). Every
// tick yields one output request with the serial clock level, busy flag,
// reading-done flag, raw, tare and weight values and a weight-updated flag.
// Config writes (half period, gain) go through i_cfg_we/i_cfg_index/
// i_cfg_data and take effect on the next tick; write them only while idle.
// Timing: the result of a tick is registered and valid in the cycle after it
// is accepted, and a tick is taken every cycle (see Stall). The exception is
// the completing tick of a weigh reading above tare: the 32-step restoring
// divider runs one quotient bit per cycle, so that result is registered once
// the divider finishes, and input is held off meanwhile.
// Reset: sequencer idle, serial clock high (converter powered down), raw,
// tare and weight cleared, half period 1, gain 1386.
// Stall: while a result waits on i_out_ready, a new tick is taken only in the
// cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare #(
    parameter int READINGS_PER_WEIGH = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic                              i_dout_level,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_sck_level,
    output logic                              o_busy_res,
    output logic                              o_reading_done,
    output logic [lcar_pkg::DATA_BITS-1:0]    o_raw_value,
    output logic [lcar_pkg::DATA_BITS-1:0]    o_tare_value,
    output logic [lcar_pkg::DATA_BITS-1:0]    o_weight_value,
    output logic                              o_weight_updated,
    input  logic                              i_cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lcar_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lcar_ctrl #(
        .READINGS_PER_WEIGH (READINGS_PER_WEIGH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_dout      (i_dout_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_sck       (o_sck_level),
        .o_busy      (o_busy_res),
        .o_done      (o_reading_done),
        .o_updated   (o_weight_updated)
    );

    lcar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_dout      (i_dout_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_raw       (o_raw_value),
        .o_tare      (o_tare_value),
        .o_weight    (o_weight_value)
    );

endmodule

/* dv/load_cell_adc_reader_with_tare_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_tare_tb
// Self-checking bench for the load cell reader with tare. Ticks carry
// data-out levels shaped into whole conversions, with noise while waiting
// and between sample points. A tick-level model of the sequencer predicts
// every output request, and each one is compared field by field. Both
// handshakes see random bursts of idle cycles.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare_tb;
    import lcar_pkg::*;

    localparam int         READS_PER_WEIGH = 5;
    localparam int         RANDOM_TICKS    = 500;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         MAX_REPORTS     = 200;
    localparam longint     TIMEOUT_NS      = 2_000_000;
    localparam logic [1:0] ACT_SPARE       = 2'd3;

    typedef struct packed {
        logic                 sck;
        logic                 busy;
        logic                 done;
        logic [DATA_BITS-1:0] raw;
        logic [DATA_BITS-1:0] tare;
        logic [DATA_BITS-1:0] weight;
        logic                 updated;
    } t_readout;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [1:0]            i_action     = ACT_NONE;
    logic                  i_dout_level = 1'b1;
    logic                  i_out_ready  = 1'b1;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_sck_level;
    logic                  o_busy_res;
    logic                  o_reading_done;
    logic [DATA_BITS-1:0]  o_raw_value;
    logic [DATA_BITS-1:0]  o_tare_value;
    logic [DATA_BITS-1:0]  o_weight_value;
    logic                  o_weight_updated;

    load_cell_adc_reader_with_tare #(
        .READINGS_PER_WEIGH(READS_PER_WEIGH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_dout_level     (i_dout_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_sck_level      (o_sck_level),
        .o_busy_res       (o_busy_res),
        .o_reading_done   (o_reading_done),
        .o_raw_value      (o_raw_value),
        .o_tare_value     (o_tare_value),
        .o_weight_value   (o_weight_value),
        .o_weight_updated (o_weight_updated),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // reader model state
    t_phase               mdl_phase;
    logic [DATA_BITS-1:0] mdl_shift;
    logic [BITCNT_W-1:0]  mdl_bits;
    logic [TIMER_W-1:0]   mdl_timer;
    logic [TIMER_W-1:0]   mdl_half;
    logic [GAIN_W-1:0]    mdl_gain;
    logic [2:0]           mdl_left;
    logic                 mdl_tare_mode;
    logic                 mdl_sck;
    logic [DATA_BITS-1:0] mdl_raw;
    logic [DATA_BITS-1:0] mdl_tare;
    logic [DATA_BITS-1:0] mdl_weight;
    logic                 mdl_new_reading;

    t_readout             readout_q[$];
    logic [DATA_BITS-1:0] word_q[$];
    logic [DATA_BITS-1:0] conv_word = '0;

    bit quiet     = 1'b0;
    int gap_pct   = 20;
    int stall_pct = 20;
    int wait_odds = 3;
    int n_fail    = 0;
    int n_ticks   = 0;
    int n_tare_reads  = 0;
    int n_weigh_reads = 0;
    int n_updates     = 0;

    task automatic reset_model();
        mdl_phase       = PH_IDLE;
        mdl_shift       = '0;
        mdl_bits        = '0;
        mdl_timer       = '0;
        mdl_half        = HALF_RST;
        mdl_gain        = GAIN_RST;
        mdl_left        = '0;
        mdl_tare_mode   = 1'b0;
        mdl_sck         = 1'b1;
        mdl_raw         = '0;
        mdl_tare        = '0;
        mdl_weight      = '0;
        mdl_new_reading = 1'b0;
    endtask

    function automatic logic [TIMER_W-1:0] half_len();
        return (mdl_half == '0) ? TIMER_W'(1) : mdl_half;
    endfunction

    function automatic bit level_elapsed();
        if (mdl_timer <= 1)
            return 1'b1;
        mdl_timer = mdl_timer - 1'b1;
        return 1'b0;
    endfunction

    task automatic begin_reading();
        mdl_sck         = 1'b0;
        mdl_shift       = '0;
        mdl_bits        = '0;
        mdl_timer       = '0;
        mdl_phase       = PH_WAIT;
        mdl_new_reading = 1'b1;
    endtask

    task automatic compute_readout(input logic [1:0] act, input logic dout);
        logic                 done;
        logic                 upd;
        logic [DATA_BITS-1:0] diff;
        logic [NUM_W-1:0]     num;
        logic [GAIN_W-1:0]    g;
        done = 1'b0;
        upd  = 1'b0;
        case (mdl_phase)
            PH_IDLE: begin
                if (act == ACT_TARE) begin
                    mdl_tare_mode = 1'b1;
                    mdl_left      = 3'd1;
                    begin_reading();
                end else if (act == ACT_WEIGH) begin
                    mdl_tare_mode = 1'b0;
                    mdl_left      = (3'(READS_PER_WEIGH) == 3'd0) ? 3'd1 : 3'(READS_PER_WEIGH);
                    begin_reading();
                end
            end
            PH_WAIT: begin
                if (!dout) begin
                    mdl_sck   = 1'b1;
                    mdl_timer = half_len();
                    mdl_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (level_elapsed()) begin
                    mdl_sck   = 1'b0;
                    mdl_shift = {mdl_shift[DATA_BITS-2:0], dout};
                    mdl_bits  = mdl_bits + 1'b1;
                    mdl_timer = half_len();
                    mdl_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (level_elapsed()) begin
                    mdl_sck   = 1'b1;
                    mdl_timer = half_len();
                    mdl_phase = (mdl_bits < DATA_BITS) ? PH_HIGH : PH_LAST_HIGH;
                end
            end
            PH_LAST_HIGH: begin
                if (level_elapsed()) begin
                    mdl_sck = 1'b0;
                    mdl_raw = mdl_shift ^ SIGN_FLIP;
                    done    = 1'b1;
                    if (mdl_tare_mode) begin
                        mdl_tare = mdl_raw;
                        n_tare_reads++;
                    end else begin
                        n_weigh_reads++;
                        if (mdl_raw > mdl_tare) begin
                            g          = (mdl_gain < GAIN_MIN) ? GAIN_MIN : mdl_gain;
                            diff       = mdl_raw - mdl_tare;
                            num        = {diff, 8'h00};
                            mdl_weight = DATA_BITS'(num / g);
                            upd        = 1'b1;
                            n_updates++;
                        end
                    end
                    if (mdl_left > 1) begin
                        mdl_left = mdl_left - 1'b1;
                        begin_reading();
                    end else begin
                        mdl_left  = '0;
                        mdl_phase = PH_IDLE;
                    end
                end
            end
            default: mdl_phase = PH_IDLE;
        endcase
        readout_q.push_back('{sck: mdl_sck, busy: (mdl_phase != PH_IDLE), done: done,
                              raw: mdl_raw, tare: mdl_tare, weight: mdl_weight,
                              updated: upd});
    endtask

    task automatic send_tick(input logic [1:0] act, input logic dout);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_dout_level <= dout;
        do @(posedge i_clk); while (!o_in_ready);
        compute_readout(act, dout);
        n_ticks++;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (readout_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_HALF_PERIOD)
            mdl_half = data[TIMER_W-1:0];
        else
            mdl_gain = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_BITS-1:0] random_word();
        logic [DATA_BITS-1:0] near;
        near = mdl_tare + DATA_BITS'($urandom_range(0, 4)) - DATA_BITS'(2);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 24'h000000;
                    1:       return 24'hFFFFFF;
                    2:       return 24'h800000;
                    default: return 24'h7FFFFF;
                endcase
            end
            1:       return near ^ SIGN_FLIP;
            default: return DATA_BITS'($urandom);
        endcase
    endfunction

    // data-out level the converter would show for the model's next tick
    function automatic logic next_dout();
        if (mdl_phase == PH_WAIT)
            return ($urandom_range(0, wait_odds) == 0) ? 1'b0 : 1'b1;
        if (mdl_phase == PH_HIGH && mdl_timer <= 1)
            return conv_word[DATA_BITS-1-mdl_bits];
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic run_sequence(input logic [1:0] act);
        send_tick(act, 1'($urandom_range(0, 1)));
        while (mdl_phase != PH_IDLE) begin
            if (mdl_new_reading) begin
                if (word_q.size() != 0)
                    conv_word = word_q.pop_front();
                else
                    conv_word = random_word();
                mdl_new_reading = 1'b0;
            end
            // actions while busy must be ignored
            send_tick(2'($urandom_range(0, 3)), next_dout());
        end
    endtask

    task automatic test_idle_ticks();
        send_tick(ACT_NONE, 1'b0);
        send_tick(ACT_NONE, 1'b1);
        send_tick(ACT_SPARE, 1'b0);
        send_tick(ACT_SPARE, 1'b1);
    endtask

    task automatic test_weigh_extremes();
        write_reg(CFG_HALF_PERIOD, 16'd1);
        // gains below 1.0 act as 1.0
        write_reg(CFG_GAIN, 16'd0);
        word_q = {24'h800000};
        run_sequence(ACT_TARE);
        // full scale, equal to tare, one above, mid and just below mid
        word_q = {24'h7FFFFF, 24'h800000, 24'h800001, 24'h000000, 24'hFFFFFF};
        run_sequence(ACT_WEIGH);
        write_reg(CFG_GAIN, 16'hFFFF);
        word_q = {24'h7FFFFF, 24'h8000FF, 24'h800100};
        run_sequence(ACT_WEIGH);
    endtask

    task automatic test_tare_at_full_scale();
        write_reg(CFG_GAIN, GAIN_RST);
        word_q = {24'h7FFFFF};
        run_sequence(ACT_TARE);
        // nothing can exceed the tare, weight must hold
        word_q = {24'h7FFFFF, 24'hFFFFFF, 24'h000000, 24'h800000, 24'h7FFFFE};
        run_sequence(ACT_WEIGH);
    endtask

    task automatic test_half_period_extremes();
        write_reg(CFG_HALF_PERIOD, 16'd0);
        wait_odds = 40;
        run_sequence(ACT_TARE);
        wait_odds = 3;
        write_reg(CFG_HALF_PERIOD, 16'd2);
        run_sequence(ACT_TARE);
        write_reg(CFG_HALF_PERIOD, 16'd1);
    endtask

    task automatic test_random_traffic();
        int start_ticks;
        start_ticks = n_ticks;
        while (n_ticks - start_ticks < RANDOM_TICKS) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
                wait_odds = $urandom_range(0, 6);
                case ($urandom_range(0, 9))
                    7, 8:    write_reg(CFG_HALF_PERIOD, 16'd2);
                    9:       write_reg(CFG_HALF_PERIOD, 16'($urandom_range(0, 3)));
                    default: write_reg(CFG_HALF_PERIOD, 16'd1);
                endcase
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_GAIN, 16'($urandom_range(0, 255)));
                else
                    write_reg(CFG_GAIN, 16'($urandom_range(256, 65535)));
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_tick($urandom_range(0, 1) ? ACT_SPARE : ACT_NONE,
                              1'($urandom_range(0, 1)));
            end else begin
                run_sequence(($urandom_range(0, 9) < 4) ? ACT_TARE : ACT_WEIGH);
            end
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        write_reg(CFG_HALF_PERIOD, 16'd1);
        run_sequence(ACT_TARE);
        repeat (4) send_tick(ACT_NONE, 1'($urandom_range(0, 1)));
    endtask

    always begin
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            i_out_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [DATA_BITS-1:0] want,
                               input logic [DATA_BITS-1:0] got);
        if (want !== got) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_readout want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (readout_q.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("%0t: unexpected output request, expected none, actual raw %0h",
                             $time, o_raw_value);
            end else begin
                want = readout_q.pop_front();
                check_field("sck_level", want.sck, o_sck_level);
                check_field("busy_res", want.busy, o_busy_res);
                check_field("reading_done", want.done, o_reading_done);
                check_field("raw_value", want.raw, o_raw_value);
                check_field("tare_value", want.tare, o_tare_value);
                check_field("weight_value", want.weight, o_weight_value);
                check_field("weight_updated", want.updated, o_weight_updated);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_ticks();
        test_weigh_extremes();
        test_tare_at_full_scale();
        test_half_period_extremes();
        test_random_traffic();
        test_quiet_tail();
        i_in_valid <= 1'b0;
        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("ran %0d ticks: %0d tare and %0d weigh readings, %0d weight updates",
                 n_ticks, n_tare_reads, n_weigh_reads, n_updates);
        $display("half periods 0 to 3, gains 0 to 65535, mismatches %0d", n_fail);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lcar_pkg.sv
hw/rtl/lcar_dp.sv
hw/rtl/lcar_ctrl.sv
hw/rtl/load_cell_adc_reader_with_tare.sv
dv/load_cell_adc_reader_with_tare_tb.sv
